/* design/sgsb_pkg.sv */
// ----------------------------------------------------------------------------
// sgsb_pkg
// Shared types, widths, register codes and reset values of the stereo gain
// block with smoothed gain and bypass crossfade.
// ----------------------------------------------------------------------------
package sgsb_pkg;

    localparam int SAMPLE_WIDTH_DEF    = 24;
    localparam int BYPASS_RAMP_LEN_DEF = 64;

    localparam int GAIN_W      = 24;
    localparam int CUR_W       = 32;
    localparam int RAMP_W      = 13;
    localparam int MODE_W      = 2;
    localparam int XF_W        = 17;
    localparam int GAIN_EXTRA  = 8;
    localparam int GAIN_FRAC   = 28;
    localparam int XF_FRAC     = 16;
    localparam int DVD_W       = 33;
    localparam int DIV_STEPS   = 33;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int UNITY_XF_INT = 65536;

    localparam logic [XF_W-1:0]   UNITY_XF   = 17'h10000;
    localparam logic [GAIN_W-1:0] TARGET_RST = 24'h100000;
    localparam logic [RAMP_W-1:0] RAMP_RST   = 13'd882;
    localparam logic [CUR_W-1:0]  CUR_RST    = 32'h1000_0000;

    localparam logic [MODE_W-1:0] MODE_STEREO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIDE   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_GAIN  = 2'd0,
        CFG_CHANNEL_MODE = 2'd1,
        CFG_BYPASS_ON    = 2'd2,
        CFG_RAMP_STEPS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  valid;
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic load_in;
        logic latch;
        logic advance;
        logic gain_l;
        logic gain_r;
        logic blend0;
        logic blend1;
        logic blend2;
        logic blend3;
        logic blend4;
        logic blend5;
        logic load_out;
        logic out_dry;
    } t_cmd;

    typedef struct packed {
        logic tgt_change;
        logic ramp_zero;
        logic full_bypass;
        logic div_busy;
        logic div_done;
    } t_status;

endpackage

/* design/sgsb_div.sv */
// ----------------------------------------------------------------------------
// sgsb_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module sgsb_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [sgsb_pkg::DVD_W-1:0]  i_dividend,
    input  logic        [sgsb_pkg::RAMP_W-1:0] i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic        [sgsb_pkg::CUR_W-1:0]  o_quotient
);

    localparam int DW = sgsb_pkg::DVD_W;
    localparam int RW = sgsb_pkg::RAMP_W;

    logic                           r_busy;
    logic                           r_done;
    logic [sgsb_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_neg;
    logic [DW-1:0]                  r_dvd;
    logic [RW-1:0]                  r_rem;
    logic [RW-1:0]                  r_d;
    logic [RW:0]                    trial;
    logic                           fits;

    assign trial = {r_rem, r_dvd[DW-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sgsb_pkg::CNT_W'(sgsb_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == sgsb_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DW-1];
            r_dvd <= i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? RW'(trial - {1'b0, r_d}) : trial[RW-1:0];
            r_dvd <= {r_dvd[DW-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (sgsb_pkg::CUR_W)'(-r_dvd[sgsb_pkg::CUR_W-1:0])
                              : r_dvd[sgsb_pkg::CUR_W-1:0];

endmodule

/* design/sgsb_dp.sv */
// ----------------------------------------------------------------------------
// sgsb_dp
// Datapath: configuration registers, gain smoother, crossfade level, shared
// gain and blend multipliers, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module sgsb_dp #(
    parameter int SAMPLE_WIDTH    = sgsb_pkg::SAMPLE_WIDTH_DEF,
    parameter int BYPASS_RAMP_LEN = sgsb_pkg::BYPASS_RAMP_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sgsb_pkg::t_cfg_wr              i_cfg,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_left,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_right,
    input  sgsb_pkg::t_cmd                 i_cmd,
    output sgsb_pkg::t_status              o_status,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_left,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_right
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int WW  = W + 1;
    localparam int GW  = W + 5;
    localparam int GP  = WW + sgsb_pkg::CUR_W + 1;
    localparam int BP  = GW + sgsb_pkg::XF_W + 1;
    localparam int AW  = BP + 1;
    localparam int XW  = sgsb_pkg::XF_W;
    localparam logic [XW-1:0] XF_STEP = XW'(sgsb_pkg::UNITY_XF_INT / BYPASS_RAMP_LEN);
    localparam logic signed [GP-1:0] G_HALF = GP'(1) << (sgsb_pkg::GAIN_FRAC - 1);
    localparam logic signed [AW-1:0] A_HALF = AW'(1) << (sgsb_pkg::XF_FRAC - 1);

    logic [sgsb_pkg::GAIN_W-1:0] r_target;
    logic [sgsb_pkg::MODE_W-1:0] r_mode;
    logic                        r_bypass;
    logic [sgsb_pkg::RAMP_W-1:0] r_ramp;

    logic [sgsb_pkg::CUR_W-1:0]  r_cur, n_cur;
    logic [sgsb_pkg::CUR_W-1:0]  r_inc, n_inc;
    logic [sgsb_pkg::RAMP_W-1:0] r_steps, n_steps;
    logic [sgsb_pkg::GAIN_W-1:0] r_latched, n_latched;
    logic [XW-1:0]               r_lvl, n_lvl;

    logic signed [W-1:0]  r_l, r_r;
    logic signed [WW-1:0] r_wl, r_wr;
    logic signed [GP-1:0] r_gprod;
    logic signed [GW-1:0] r_gwl, r_gwr;
    logic signed [BP-1:0] r_bprod;
    logic signed [AW-1:0] r_acc;
    logic signed [W-1:0]  r_resl, r_resr;
    logic signed [W-1:0]  r_outl, r_outr;

    logic [sgsb_pkg::CUR_W-1:0]  full;
    logic [sgsb_pkg::RAMP_W-1:0] steps_dec;
    logic signed [sgsb_pkg::DVD_W-1:0] diff_gain;
    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic [sgsb_pkg::CUR_W-1:0]  div_q;
    logic [XW:0]                 lvl_up;
    logic [XW-1:0]               goal;

    logic signed [WW-1:0] sum_lr, dif_lr, half_sum, half_dif;
    logic signed [WW-1:0] wet_l, wet_r;
    logic signed [WW-1:0] gmul_a;
    logic signed [GP-1:0] g_rnd;
    logic signed [GW-1:0] g_val;
    logic signed [GW-1:0] bmul_a;
    logic        [XW-1:0] bmul_b;
    logic signed [AW-1:0] a_rnd, a_shift;
    logic signed [W-1:0]  a_sat;
    logic                 a_fits;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= sgsb_pkg::TARGET_RST;
            r_mode   <= sgsb_pkg::MODE_STEREO;
            r_bypass <= 1'b0;
            r_ramp   <= sgsb_pkg::RAMP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sgsb_pkg::CFG_TARGET_GAIN:  r_target <= i_cfg.data;
                sgsb_pkg::CFG_CHANNEL_MODE: r_mode   <= i_cfg.data[sgsb_pkg::MODE_W-1:0];
                sgsb_pkg::CFG_BYPASS_ON:    r_bypass <= i_cfg.data[0];
                sgsb_pkg::CFG_RAMP_STEPS:   r_ramp   <= i_cfg.data[sgsb_pkg::RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // gain smoother and crossfade level
    assign full      = {r_target, {sgsb_pkg::GAIN_EXTRA{1'b0}}};
    assign steps_dec = r_steps - 1'b1;
    assign diff_gain = $signed({1'b0, full}) - $signed({1'b0, r_cur});
    assign div_start = i_cmd.latch && o_status.tgt_change && !o_status.ramp_zero;
    assign goal      = r_bypass ? '0 : sgsb_pkg::UNITY_XF;
    assign lvl_up    = {1'b0, r_lvl} + {1'b0, XF_STEP};

    always_comb begin
        n_cur     = r_cur;
        n_inc     = r_inc;
        n_steps   = r_steps;
        n_latched = r_latched;
        n_lvl     = r_lvl;
        if (i_cmd.latch && o_status.tgt_change) begin
            n_latched = r_target;
            if (o_status.ramp_zero) begin
                n_cur   = full;
                n_steps = '0;
                n_inc   = '0;
            end else begin
                n_steps = r_ramp;
            end
        end
        if (div_done) begin
            n_inc = div_q;
        end
        if (i_cmd.advance) begin
            if (r_steps != '0) begin
                n_steps = steps_dec;
                n_cur   = (steps_dec != '0) ? r_cur + r_inc
                                            : {r_latched, {sgsb_pkg::GAIN_EXTRA{1'b0}}};
            end
            if (r_lvl != goal) begin
                if (r_bypass) begin
                    n_lvl = (r_lvl < XF_STEP) ? '0 : r_lvl - XF_STEP;
                end else begin
                    n_lvl = (lvl_up > {1'b0, sgsb_pkg::UNITY_XF}) ? sgsb_pkg::UNITY_XF
                                                                  : lvl_up[XW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= sgsb_pkg::CUR_RST;
            r_inc     <= '0;
            r_steps   <= '0;
            r_latched <= sgsb_pkg::TARGET_RST;
            r_lvl     <= sgsb_pkg::UNITY_XF;
        end else begin
            r_cur     <= n_cur;
            r_inc     <= n_inc;
            r_steps   <= n_steps;
            r_latched <= n_latched;
            r_lvl     <= n_lvl;
        end
    end

    sgsb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff_gain),
        .i_divisor  (r_ramp),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // wet pair
    assign sum_lr   = $signed({r_l[W-1], r_l}) + $signed({r_r[W-1], r_r});
    assign dif_lr   = $signed({r_l[W-1], r_l}) - $signed({r_r[W-1], r_r});
    assign half_sum = sum_lr >>> 1;
    assign half_dif = dif_lr >>> 1;

    always_comb begin
        unique case (r_mode)
            sgsb_pkg::MODE_STEREO: begin
                wet_l = {r_l[W-1], r_l};
                wet_r = {r_r[W-1], r_r};
            end
            sgsb_pkg::MODE_MONO: begin
                wet_l = half_sum;
                wet_r = half_sum;
            end
            default: begin
                wet_l = half_dif;
                wet_r = -half_dif;
            end
        endcase
    end

    // gain multiply, round half away from zero
    assign gmul_a = i_cmd.gain_l ? r_wl : r_wr;
    assign g_rnd  = r_gprod + (r_gprod[GP-1] ? G_HALF - GP'(1) : G_HALF);
    assign g_val  = g_rnd[GW+sgsb_pkg::GAIN_FRAC-1:sgsb_pkg::GAIN_FRAC];

    // blend multiply
    always_comb begin
        priority if (i_cmd.blend0) begin
            bmul_a = {{(GW-W){r_l[W-1]}}, r_l};
            bmul_b = sgsb_pkg::UNITY_XF - r_lvl;
        end else if (i_cmd.blend1) begin
            bmul_a = r_gwl;
            bmul_b = r_lvl;
        end else if (i_cmd.blend2) begin
            bmul_a = {{(GW-W){r_r[W-1]}}, r_r};
            bmul_b = sgsb_pkg::UNITY_XF - r_lvl;
        end else begin
            bmul_a = r_gwr;
            bmul_b = r_lvl;
        end
    end

    assign a_rnd   = r_acc + (r_acc[AW-1] ? A_HALF - AW'(1) : A_HALF);
    assign a_shift = a_rnd >>> sgsb_pkg::XF_FRAC;
    assign a_fits  = (&a_shift[AW-1:W-1]) || !(|a_shift[AW-1:W-1]);
    assign a_sat   = a_fits ? a_shift[W-1:0]
                            : (a_shift[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_l <= i_in_left;
            r_r <= i_in_right;
        end
        if (i_cmd.advance) begin
            r_wl <= wet_l;
            r_wr <= wet_r;
        end
        if (i_cmd.gain_l || i_cmd.gain_r) begin
            r_gprod <= gmul_a * $signed({1'b0, r_cur});
        end
        if (i_cmd.gain_r) begin
            r_gwl <= g_val;
        end
        if (i_cmd.blend0) begin
            r_gwr <= g_val;
        end
        if (i_cmd.blend0 || i_cmd.blend1 || i_cmd.blend2 || i_cmd.blend3) begin
            r_bprod <= bmul_a * $signed({1'b0, bmul_b});
        end
        if (i_cmd.blend1 || i_cmd.blend3) begin
            r_acc <= {r_bprod[BP-1], r_bprod};
        end else if (i_cmd.blend2 || i_cmd.blend4) begin
            r_acc <= r_acc + {r_bprod[BP-1], r_bprod};
        end
        if (i_cmd.blend3) begin
            r_resl <= a_sat;
        end
        if (i_cmd.blend5) begin
            r_resr <= a_sat;
        end
        if (i_cmd.load_out) begin
            r_outl <= i_cmd.out_dry ? r_l : r_resl;
            r_outr <= i_cmd.out_dry ? r_r : r_resr;
        end
    end

    assign o_status.tgt_change  = r_target != r_latched;
    assign o_status.ramp_zero   = r_ramp == '0;
    assign o_status.full_bypass = r_bypass && (r_lvl == '0);
    assign o_status.div_busy    = div_busy;
    assign o_status.div_done    = div_done;

    assign o_out_left  = r_outl;
    assign o_out_right = r_outr;

endmodule

/* design/sgsb_ctrl.sv */
// ----------------------------------------------------------------------------
// sgsb_ctrl
// Controller: sequences one item at a time through target latch, increment
// division, smoother advance, gain and blend multiplies and output load.
// ----------------------------------------------------------------------------
module sgsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  sgsb_pkg::t_status i_status,
    output sgsb_pkg::t_cmd    o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LATCH = 14'b00000000000010,
        S_DIV   = 14'b00000000000100,
        S_ADV   = 14'b00000000001000,
        S_GL    = 14'b00000000010000,
        S_GR    = 14'b00000000100000,
        S_BL0   = 14'b00000001000000,
        S_BL1   = 14'b00000010000000,
        S_BL2   = 14'b00000100000000,
        S_BL3   = 14'b00001000000000,
        S_BL4   = 14'b00010000000000,
        S_BL5   = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_HOLD  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_dry, n_dry;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        n_dry   = r_dry;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_LATCH;
                end
            end
            S_LATCH: begin
                o_cmd.latch = 1'b1;
                n_dry       = i_status.full_bypass;
                if (i_status.tgt_change && !i_status.ramp_zero) begin
                    n_state = S_DIV;
                end else if (i_status.full_bypass) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = r_dry ? S_OUT : S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_GL;
            end
            S_GL: begin
                o_cmd.gain_l = 1'b1;
                n_state      = S_GR;
            end
            S_GR: begin
                o_cmd.gain_r = 1'b1;
                n_state      = S_BL0;
            end
            S_BL0: begin
                o_cmd.blend0 = 1'b1;
                n_state      = S_BL1;
            end
            S_BL1: begin
                o_cmd.blend1 = 1'b1;
                n_state      = S_BL2;
            end
            S_BL2: begin
                o_cmd.blend2 = 1'b1;
                n_state      = S_BL3;
            end
            S_BL3: begin
                o_cmd.blend3 = 1'b1;
                n_state      = S_BL4;
            end
            S_BL4: begin
                o_cmd.blend4 = 1'b1;
                n_state      = S_BL5;
            end
            S_BL5: begin
                o_cmd.blend5 = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_dry  = r_dry;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dry       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dry       <= n_dry;
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;

    a_accept_to_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> (r_state == S_LATCH))
        else $error("accepted item did not start the latch step");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_done) |=> (r_state == S_ADV || r_state == S_OUT))
        else $error("controller did not leave the divide wait on completion");

    a_div_idle_at_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LATCH) |-> !i_status.div_busy)
        else $error("divider still busy when a new target is latched");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten while holding an untaken item");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded output not marked valid");

endmodule

/* design/stereo_gain_smoothed_bypass_top.sv */
// ----------------------------------------------------------------------------
// stereo_gain_smoothed_bypass_top
// Stereo gain with linear gain smoothing, channel modes and bypass crossfade.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one stereo sample pair per item; output stream
//   m_axis returns one processed pair per item, in order. The cfg channel
//   writes target_gain, channel_mode, bypass_on and ramp_steps (index 0..3);
//   it is always ready and must be written only while the block is idle;
//   the block itself does not enforce this. One item is in flight at a time.
//   An item steps from accept through the target latch, smoother advance and
//   the sequence of shared gain and blend multiplies to the output load
//   before the next accept. An item that latches a new target with a nonzero
//   ramp length also waits for the bit-serial increment divider (one quotient
//   bit a cycle). Fully bypassed items skip the advance and the multiplies.
//   The result sits in an output register, so the next item is accepted while
//   the receiver stalls; a further result waits until that register empties.
//   Synchronous reset restores register defaults (unity gain, stereo pass, no
//   bypass, 882-sample ramp), puts the smoother at unity, sets the crossfade wet.
// ----------------------------------------------------------------------------
module stereo_gain_smoothed_bypass_top #(
    parameter int SAMPLE_WIDTH    = sgsb_pkg::SAMPLE_WIDTH_DEF,
    parameter int BYPASS_RAMP_LEN = sgsb_pkg::BYPASS_RAMP_LEN_DEF,
    parameter int TDATA_W         = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [TDATA_W-1:0]                i_s_axis_tdata,  // in_left, in_right
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [TDATA_W-1:0]                o_m_axis_tdata,  // out_left, out_right
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sgsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sgsb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int W = SAMPLE_WIDTH;

    sgsb_pkg::t_cfg_wr cfg;
    sgsb_pkg::t_cmd    cmd;
    sgsb_pkg::t_status status;
    logic signed [W-1:0] out_left;
    logic signed [W-1:0] out_right;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = sgsb_pkg::t_cfg_idx'(i_cfg_index);
    assign cfg.data    = i_cfg_data;

    sgsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sgsb_dp #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .BYPASS_RAMP_LEN (BYPASS_RAMP_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_left   (i_s_axis_tdata[W-1:0]),
        .i_in_right  (i_s_axis_tdata[2*W-1:W]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_left  (out_left),
        .o_out_right (out_right)
    );

    assign o_m_axis_tdata = TDATA_W'({out_right, out_left});

endmodule

/* tb/tb_stereo_gain_smoothed_bypass_top.sv */
// ----------------------------------------------------------------------------
// tb_stereo_gain_smoothed_bypass_top
// Self-checking bench for the stereo gain block. A scoreboard class predicts
// every output pair from the register settings in force: channel modes, the
// linear gain ramp with its snap to target, the bypass crossfade and full
// bypass with a frozen smoother. Directed pairs hit the sample extremes and
// each mode. Random phases then change registers between drained runs. The
// sender idles in bursts, the receiver stalls on its own pattern, and one
// long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_stereo_gain_smoothed_bypass_top;
    import sgsb_pkg::*;

    localparam int SW            = SAMPLE_WIDTH_DEF;
    localparam int TDW           = ((2 * SW + 7) / 8) * 8;
    localparam int DIRECTED      = 25;
    localparam int RANDOM_ITEMS  = 700;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int XF_STEP       = UNITY_XF_INT / BYPASS_RAMP_LEN_DEF;
    localparam int MAX_REPORTS   = 10;

    localparam logic [MODE_W-1:0] MODE_SIDE_ALIAS = 2'd3;
    localparam logic [SW-1:0]     SMAX            = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0]     SMIN            = {1'b1, {(SW - 1){1'b0}}};
    localparam logic [SW-1:0]     NEG_ONE         = {SW{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_MAX        = {GAIN_W{1'b1}};
    localparam logic [RAMP_W-1:0] RAMP_MAX        = {RAMP_W{1'b1}};

    typedef struct {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
    } t_stereo_pair;

    class gain_scoreboard;
        logic [GAIN_W-1:0] tgt_reg;
        logic [MODE_W-1:0] mode_reg;
        logic              bypass_reg;
        logic [RAMP_W-1:0] ramp_reg;

        logic [CUR_W-1:0]  gain_q28;
        logic [CUR_W-1:0]  gain_inc;
        logic [RAMP_W-1:0] steps_left;
        logic [GAIN_W-1:0] held_tgt;
        int                xf_level;

        t_stereo_pair      expected_q[$];
        int                mismatches;
        int                results_checked;
        int                pairs_in;
        int                reg_writes;
        int                full_bypass_pairs;

        function new();
            tgt_reg           = TARGET_RST;
            mode_reg          = MODE_STEREO;
            bypass_reg        = 1'b0;
            ramp_reg          = RAMP_RST;
            gain_q28          = CUR_RST;
            gain_inc          = '0;
            steps_left        = '0;
            held_tgt          = TARGET_RST;
            xf_level          = UNITY_XF_INT;
            mismatches        = 0;
            results_checked   = 0;
            pairs_in          = 0;
            reg_writes        = 0;
            full_bypass_pairs = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_TARGET_GAIN:  tgt_reg    = data[GAIN_W-1:0];
                CFG_CHANNEL_MODE: mode_reg   = data[MODE_W-1:0];
                CFG_BYPASS_ON:    bypass_reg = data[0];
                CFG_RAMP_STEPS:   ramp_reg   = data[RAMP_W-1:0];
                default: ;
            endcase
        endfunction

        function longint scale_round(longint v, longint unsigned f, int sh);
            longint unsigned mag;
            longint unsigned q;
            mag = (v < 0) ? -v : v;
            q   = (mag * f + (64'd1 << (sh - 1))) >> sh;
            return (v < 0) ? -longint'(q) : longint'(q);
        endfunction

        function logic [SW-1:0] clip(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (SW - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return SMAX;
            if (v < lo) return SMIN;
            return v[SW-1:0];
        endfunction

        function void note_input(logic [TDW-1:0] data);
            longint       l, r, wl, wr, s;
            longint       full_l, cur_l, len_l, quot;
            longint       mix_l, mix_r;
            logic [CUR_W-1:0] full;
            int           goal, dry;
            t_stereo_pair p;
            l = $signed(data[SW-1:0]);
            r = $signed(data[2*SW-1:SW]);
            pairs_in++;
            goal = bypass_reg ? 0 : UNITY_XF_INT;

            if (tgt_reg != held_tgt) begin
                held_tgt = tgt_reg;
                full     = {tgt_reg, {GAIN_EXTRA{1'b0}}};
                if (ramp_reg == 0) begin
                    gain_q28   = full;
                    steps_left = '0;
                    gain_inc   = '0;
                end else begin
                    full_l     = full;
                    cur_l      = gain_q28;
                    len_l      = ramp_reg;
                    quot       = (full_l - cur_l) / len_l;
                    steps_left = ramp_reg;
                    gain_inc   = quot[CUR_W-1:0];
                end
            end

            if (goal == 0 && xf_level == 0) begin
                p.left  = data[SW-1:0];
                p.right = data[2*SW-1:SW];
                full_bypass_pairs++;
                expected_q.push_back(p);
                return;
            end

            case (mode_reg)
                MODE_STEREO: begin
                    wl = l;
                    wr = r;
                end
                MODE_MONO: begin
                    wl = (l + r) >>> 1;
                    wr = wl;
                end
                default: begin
                    s  = (l - r) >>> 1;
                    wl = s;
                    wr = -s;
                end
            endcase

            if (steps_left != 0) begin
                steps_left = steps_left - 1'b1;
                if (steps_left != 0) gain_q28 = gain_q28 + gain_inc;
                else gain_q28 = {held_tgt, {GAIN_EXTRA{1'b0}}};
            end
            wl = scale_round(wl, gain_q28, GAIN_FRAC);
            wr = scale_round(wr, gain_q28, GAIN_FRAC);

            if (xf_level != goal) begin
                if (goal > xf_level) begin
                    xf_level = (xf_level + XF_STEP > UNITY_XF_INT) ? UNITY_XF_INT
                                                                  : xf_level + XF_STEP;
                end else begin
                    xf_level = (xf_level < XF_STEP) ? 0 : xf_level - XF_STEP;
                end
            end

            dry     = UNITY_XF_INT - xf_level;
            mix_l   = scale_round(l * dry + wl * xf_level, 1, XF_FRAC);
            mix_r   = scale_round(r * dry + wr * xf_level, 1, XF_FRAC);
            p.left  = clip(mix_l);
            p.right = clip(mix_r);
            expected_q.push_back(p);
        endfunction

        function void check_result(logic [TDW-1:0] data);
            t_stereo_pair  want;
            logic [SW-1:0] got_l;
            logic [SW-1:0] got_r;
            got_l = data[SW-1:0];
            got_r = data[2*SW-1:SW];
            if (expected_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected output pair L=%0d R=%0d",
                             $realtime, $signed(got_l), $signed(got_r));
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got_l !== want.left || got_r !== want.right) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: pair %0d expected L=%0d R=%0d, got L=%0d R=%0d",
                             $realtime, results_checked, $signed(want.left),
                             $signed(want.right), $signed(got_l), $signed(got_r));
                mismatches++;
            end
            results_checked++;
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [TDW-1:0]        i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [TDW-1:0]        o_m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gain_scoreboard sb;
    int             stall_cycles = 0;
    int             burst_left   = 0;
    bit             gapless      = 1'b0;
    bit             hold_req     = 1'b0;
    int             phases_run   = 0;

    stereo_gain_smoothed_bypass_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && sb != null) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready) sb.note_input(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
        end
        if ((i_cfg_valid && o_cfg_ready) || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : receiver
        bit [7:0] pat;
        int       cyc;
        pat = 8'hFF;
        cyc = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (cyc % 64 == 0) pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                i_m_axis_tready <= pat[cyc % 8];
                cyc++;
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMAX;
            1:       return SMIN;
            2:       return '0;
            3:       return NEG_ONE;
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [SW-1:0] l, input logic [SW-1:0] r);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 20);
            gap = gapless ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hold off the sender until every pair has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int ph);
        int               n;
        logic [GAIN_W-1:0] tgt;
        logic [RAMP_W-1:0] len;
        if ($urandom_range(0, 9) < 7 || ph == 1) begin
            case ($urandom_range(0, 9))
                0:       tgt = '0;
                1:       tgt = GAIN_MAX;
                2, 3:    tgt = TARGET_RST;
                4, 5, 6: tgt = GAIN_W'($urandom_range(0, 2 * TARGET_RST));
                default: tgt = GAIN_W'($urandom);
            endcase
            if (ph == 1 && tgt == sb.tgt_reg) tgt = ~tgt;
            write_reg(CFG_TARGET_GAIN, CFG_DATA_W'(tgt));
        end
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        if (ph <= 2)
            write_reg(CFG_BYPASS_ON, CFG_DATA_W'(ph < 2));
        else if ($urandom_range(0, 2) == 0)
            write_reg(CFG_BYPASS_ON, CFG_DATA_W'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) == 0 || ph == 1) begin
            case ($urandom_range(0, 19))
                0, 1, 2: len = '0;
                3, 4:    len = RAMP_MAX;
                5, 6:    len = RAMP_W'($urandom);
                default: len = RAMP_W'($urandom_range(1, 64));
            endcase
            if (ph == 1) len = RAMP_W'(40);
            write_reg(CFG_RAMP_STEPS, CFG_DATA_W'(len));
        end

        n       = (ph == 0) ? 80 : $urandom_range(15, 80);
        gapless = (ph == 3) || ($urandom_range(0, 3) == 0);
        if (ph == 3) hold_req = 1'b1;
        repeat (n) send_pair(pick_sample(), pick_sample());
        drain();
    endtask

    initial begin : main
        int ph;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unity gain, stereo pass
        send_pair(SMAX, SMAX);
        send_pair(SMIN, SMIN);
        send_pair('0, '0);
        send_pair(SMAX, SMIN);
        send_pair(SMIN, SMAX);
        drain();

        write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(MODE_MONO));
        send_pair(SMAX, SMAX);
        send_pair(SMIN, SMIN);
        send_pair(NEG_ONE, '0);
        send_pair(SMAX, SMIN);
        drain();

        // side solo, with negation past the positive limit
        write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(MODE_SIDE));
        send_pair(SMIN, SMAX);
        send_pair(SMAX, SMIN);
        send_pair(SW'(-3), '0);
        drain();

        write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(MODE_SIDE_ALIAS));
        send_pair(SW'(5), SW'(-8));
        drain();

        // immediate jump to maximum gain
        write_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(MODE_STEREO));
        write_reg(CFG_RAMP_STEPS, '0);
        write_reg(CFG_TARGET_GAIN, CFG_DATA_W'(GAIN_MAX));
        send_pair(SMAX, SMIN);
        send_pair(SW'(1000), SW'(-1000));
        drain();

        // short ramp down to zero, past its snap
        write_reg(CFG_RAMP_STEPS, CFG_DATA_W'(3));
        write_reg(CFG_TARGET_GAIN, '0);
        repeat (2) send_pair(SW'(24'h123456), SW'(-24'sh123456));
        repeat (2) send_pair(SMAX, SMIN);
        drain();

        // ramp length rewritten while a ramp runs
        write_reg(CFG_TARGET_GAIN, CFG_DATA_W'(TARGET_RST));
        send_pair(SMAX, SMIN);
        drain();
        write_reg(CFG_RAMP_STEPS, CFG_DATA_W'(RAMP_MAX));
        repeat (2) send_pair(SW'(24'h3C0FF0), SW'(-24'sh0F00F0));
        drain();
        write_reg(CFG_TARGET_GAIN, CFG_DATA_W'(TARGET_RST >> 1));
        send_pair(SMAX, SMAX);
        drain();

        // start of a bypass fade
        write_reg(CFG_BYPASS_ON, CFG_DATA_W'(1));
        send_pair(SMAX, SMIN);
        send_pair(SW'(-24'sh400000), SW'(24'h400000));
        drain();

        ph = 0;
        while (sb.pairs_in < DIRECTED + RANDOM_ITEMS) begin
            random_phase(ph);
            ph++;
        end
        phases_run = ph;
        repeat (20) @(posedge i_clk);

        $display("covered %0d pairs over %0d random phases, %0d register writes",
                 sb.pairs_in, phases_run, sb.reg_writes);
        $display("%0d pairs fully bypassed, %0d results checked, %0d mismatches",
                 sb.full_bypass_pairs, sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* stereo_gain_smoothed_bypass_top.f */
design/sgsb_pkg.sv
design/sgsb_div.sv
design/sgsb_dp.sv
design/sgsb_ctrl.sv
design/stereo_gain_smoothed_bypass_top.sv
tb/tb_stereo_gain_smoothed_bypass_top.sv
